>>> design/apg_pkg.sv
// Package for the arc point generator: payload structs, constants, CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps
package apg_pkg;

    localparam int MAX_SEGMENTS_DEF = 63;
    localparam int CORDIC_STEPS_DEF = 14;
    localparam int FRAC_BITS_DEF    = 12;

    // Internal CORDIC word: Q30 plus headroom.
    localparam int CW = 33;
    localparam int ZW = 34;

    localparam logic [CW-1:0] CORDIC_X0 = 33'sd652032874;

    // Configuration register indexes.
    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_X_OFFSET = 3'd1;
    localparam logic [2:0] REG_Y_OFFSET = 3'd2;
    localparam logic [2:0] REG_X_GAIN   = 3'd3;
    localparam logic [2:0] REG_Y_GAIN   = 3'd4;

    typedef struct packed {
        logic signed [15:0] angle_begin;
        logic signed [15:0] angle_end;
        logic [5:0]         segment_count;
    } apg_in_t;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [5:0]         point_index;
        logic               clipped;
        logic               last;
    } apg_out_t;

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic                 vld;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } apg_cell_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'h20000000;
                1:  v = 32'h12E4051E;
                2:  v = 32'h09FB385B;
                3:  v = 32'h051111D4;
                4:  v = 32'h028B0D43;
                5:  v = 32'h0145D7E1;
                6:  v = 32'h00A2F61E;
                7:  v = 32'h00517C55;
                8:  v = 32'h0028BE53;
                9:  v = 32'h00145F2F;
                10: v = 32'h000A2F98;
                11: v = 32'h000517CC;
                12: v = 32'h00028BE6;
                13: v = 32'h000145F3;
                14: v = 32'h0000A2FA;
                default: v = 32'h0000517D;
            endcase
            atan_entry = $signed({2'b00, v});
        end
    endfunction

endpackage

>>> design/apg_cordic_cell.sv
// One CORDIC rotation cell: one micro-rotation per cycle on the passing word.
// Depends on apg_pkg.
`timescale 1ns / 1ps
module apg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  apg_pkg::apg_cell_t cell_in,
    output apg_pkg::apg_cell_t cell_out
);
    import apg_pkg::*;

    apg_cell_t cell_reg;
    apg_cell_t cell_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    // Arithmetic shifts floor, as the rotation requires.
    assign dx = cell_in.y >>> STEP;
    assign dy = cell_in.x >>> STEP;

    always_comb begin
        cell_next = cell_in;
        if (cell_in.z >= 0) begin
            cell_next.x = cell_in.x - dx;
            cell_next.y = cell_in.y + dy;
            cell_next.z = cell_in.z - atan_entry(STEP);
        end else begin
            cell_next.x = cell_in.x + dx;
            cell_next.y = cell_in.y - dy;
            cell_next.z = cell_in.z + atan_entry(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else begin
            cell_reg.vld <= cell_in.vld;
        end
        cell_reg.x   <= cell_next.x;
        cell_reg.y   <= cell_next.y;
        cell_reg.z   <= cell_next.z;
        cell_reg.neg <= cell_next.neg;
    end

    assign cell_out = cell_reg;
endmodule

>>> design/apg_cordic_chain.sv
// Row of CORDIC cells with angle folding at the entry and rounding at the exit.
// Depends on apg_pkg and apg_cordic_cell.
`timescale 1ns / 1ps
module apg_cordic_chain #(
    parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = apg_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [15:0] cos_out,
    output logic signed [15:0] sin_out
);
    import apg_pkg::*;

    localparam int RS = 30 - FRAC_BITS;

    apg_cell_t chain [0:CORDIC_STEPS];
    apg_cell_t head;
    logic signed [16:0] a_fold;
    logic               neg;
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yr;

    // Fold into the right half-plane; a half-turn fold negates both results.
    always_comb begin
        neg    = 1'b0;
        a_fold = {angle[15], angle};
        if ($signed(angle) >= 16'sd16384) begin
            a_fold = a_fold - 17'sd32768;
            neg    = 1'b1;
        end else if ($signed(angle) < -16'sd16384) begin
            a_fold = a_fold + 17'sd32768;
            neg    = 1'b1;
        end
        head.vld = start;
        head.x   = CORDIC_X0;
        head.y   = '0;
        head.z   = {{(ZW-33){a_fold[16]}}, a_fold, 16'd0};
        head.neg = neg;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        apg_cordic_cell #(.STEP(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_in (chain[i]),
            .cell_out(chain[i+1])
        );
    end

    // Round to FRAC_BITS, then apply the fold sign.
    assign xr = (chain[CORDIC_STEPS].x + (CW'(1) <<< (RS-1))) >>> RS;
    assign yr = (chain[CORDIC_STEPS].y + (CW'(1) <<< (RS-1))) >>> RS;

    assign done    = chain[CORDIC_STEPS].vld;
    assign cos_out = chain[CORDIC_STEPS].neg ? -xr[15:0] : xr[15:0];
    assign sin_out = chain[CORDIC_STEPS].neg ? -yr[15:0] : yr[15:0];
endmodule

>>> design/arc_point_generator.sv
// Top level of the arc point generator: request sequencer, step divider,
// coordinate multipliers, APB registers. Depends on apg_pkg and apg_cordic_chain.
//
// Usage: a request transfer on s_ carries begin angle, end angle and a segment
// count. The block emits count+1 point transfers on m_ (one when the count is
// zero), indexed from zero, the final one flagged last. Requests are taken one
// at a time; s_ready is high only between arcs.
// Each point passes through the 23-bit restoring divide of k*span by the
// count (one quotient bit per cycle, then the rotation is launched; a
// zero count skips the divide), the row of CORDIC cells, the multiply and
// saturate states, and a final step that advances to the next point.
// The divider is the per-point limit. If the receiver stalls, the finished
// point waits in the output register and the sequencer holds until it is
// taken. A synchronous low aresetn clears all control state and restores the
// register defaults (radius 0.5, gains 1.0).
// The APB port writes at the access phase; pready is always high.
`timescale 1ns / 1ps
module arc_point_generator #(
    parameter int MAX_SEGMENTS = apg_pkg::MAX_SEGMENTS_DEF,
    parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = apg_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  apg_pkg::apg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output apg_pkg::apg_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import apg_pkg::*;

    localparam int DW = 23;   // width of k*span
    localparam logic signed [31:0] HALF_LSB = 32'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_CORD, S_MUL1, S_MUL2, S_MUL3, S_OUT
    } state_t;

    // Configuration registers.
    logic signed [15:0] radius_reg, x_offset_reg, y_offset_reg, x_gain_reg, y_gain_reg;
    logic [2:0] reg_idx;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 16'sd2048;
            x_offset_reg <= '0;
            y_offset_reg <= '0;
            x_gain_reg   <= 16'sd4096;
            y_gain_reg   <= 16'sd4096;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_RADIUS:   radius_reg   <= pwdata[15:0];
                REG_X_OFFSET: x_offset_reg <= pwdata[15:0];
                REG_Y_OFFSET: y_offset_reg <= pwdata[15:0];
                REG_X_GAIN:   x_gain_reg   <= pwdata[15:0];
                REG_Y_GAIN:   y_gain_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_RADIUS:   prdata = {{16{radius_reg[15]}}, radius_reg};
            REG_X_OFFSET: prdata = {{16{x_offset_reg[15]}}, x_offset_reg};
            REG_Y_OFFSET: prdata = {{16{y_offset_reg[15]}}, y_offset_reg};
            REG_X_GAIN:   prdata = {{16{x_gain_reg[15]}}, x_gain_reg};
            REG_Y_GAIN:   prdata = {{16{y_gain_reg[15]}}, y_gain_reg};
            default:      prdata = '0;
        endcase
    end

    // Sequencer state.
    state_t              state_reg;
    logic [15:0]         start_reg;
    logic [16:0]         span_reg;
    logic [5:0]          seg_reg;
    logic [5:0]          k_reg;
    logic [DW-1:0]       dividend_reg;
    logic [DW-1:0]       quot_reg;
    logic [6:0]          rem_reg;
    logic [4:0]          bit_reg;
    logic                cord_start_reg;
    logic signed [31:0]  pc_reg, ps_reg;
    logic signed [17:0]  tc_reg, ts_reg;
    logic signed [33:0]  vx_reg, vy_reg;
    apg_out_t            out_reg;
    logic                m_valid_reg;

    logic               cord_done;
    logic signed [15:0] cos_w, sin_w;
    logic [15:0]        ang_w;
    logic [7:0]         rem_shift;
    logic [5:0]         n_sat;
    logic signed [15:0] b_sw, e_sw;

    function automatic logic ovf(input logic signed [33:0] v);
        ovf = (v > 34'sd32767) || (v < -34'sd32768);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)       sat16 = 16'sh7FFF;
        else if (v < -34'sd32768) sat16 = 16'sh8000;
        else                      sat16 = v[15:0];
    endfunction

    assign ang_w = start_reg + quot_reg[15:0];

    apg_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_chain (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cord_start_reg),
        .angle  (ang_w),
        .done   (cord_done),
        .cos_out(cos_w),
        .sin_out(sin_w)
    );

    always_comb begin
        if (s_data.angle_begin > s_data.angle_end) begin
            b_sw = s_data.angle_end;
            e_sw = s_data.angle_begin;
        end else begin
            b_sw = s_data.angle_begin;
            e_sw = s_data.angle_end;
        end
        n_sat = (s_data.segment_count > 6'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS)
                                                         : s_data.segment_count;
        rem_shift = {rem_reg, dividend_reg[DW-1]};
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Sequencer: divide, rotate, scale, deliver, one point at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            cord_start_reg <= 1'b0;
        end else begin
            cord_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        start_reg    <= b_sw;
                        span_reg     <= 17'({e_sw[15], e_sw} - {b_sw[15], b_sw});
                        seg_reg      <= n_sat;
                        k_reg        <= '0;
                        dividend_reg <= '0;
                        quot_reg     <= '0;
                        rem_reg      <= '0;
                        bit_reg      <= 5'(DW);
                        state_reg    <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One restoring-division bit per cycle.
                    if (bit_reg == 0 || seg_reg == 0) begin
                        if (seg_reg == 0) quot_reg <= '0;
                        cord_start_reg <= 1'b1;
                        state_reg      <= S_CORD;
                    end else begin
                        dividend_reg <= dividend_reg << 1;
                        if (rem_shift >= {2'b0, seg_reg}) begin
                            rem_reg  <= 7'(rem_shift - {2'b0, seg_reg});
                            quot_reg <= {quot_reg[DW-2:0], 1'b1};
                        end else begin
                            rem_reg  <= rem_shift[6:0];
                            quot_reg <= {quot_reg[DW-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
                S_CORD: begin
                    if (cord_done) begin
                        pc_reg    <= 32'(cos_w) * 32'(radius_reg);
                        ps_reg    <= 32'(sin_w) * 32'(radius_reg);
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    tc_reg    <= 18'((pc_reg + HALF_LSB) >>> FRAC_BITS) + 18'(x_offset_reg);
                    ts_reg    <= 18'((ps_reg + HALF_LSB) >>> FRAC_BITS) + 18'(y_offset_reg);
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    vx_reg    <= 34'(tc_reg) * 34'(x_gain_reg);
                    vy_reg    <= 34'(ts_reg) * 34'(y_gain_reg);
                    state_reg <= S_MUL3;
                end
                S_MUL3: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.point_x     <= sat16((vx_reg + 34'sd2048) >>> 12);
                        out_reg.point_y     <= sat16((vy_reg + 34'sd2048) >>> 12);
                        out_reg.clipped     <= ovf((vx_reg + 34'sd2048) >>> 12)
                                            || ovf((vy_reg + 34'sd2048) >>> 12);
                        out_reg.point_index <= k_reg;
                        out_reg.last        <= (k_reg == seg_reg);
                        m_valid_reg         <= 1'b1;
                        state_reg           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_reg.last) begin
                        state_reg <= S_IDLE;
                    end else begin
                        k_reg        <= k_reg + 6'd1;
                        dividend_reg <= DW'(({17'd0, k_reg} + 23'd1) * {6'd0, span_reg});
                        quot_reg     <= '0;
                        rem_reg      <= '0;
                        bit_reg      <= 5'(DW);
                        state_reg    <= S_DIV;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (m_valid_reg && m_ready && !(state_reg == S_MUL3)) m_valid_reg <= 1'b0;
        end
    end
endmodule

>>> design/arc_point_generator_checker.sv
// Port-level checker for the arc point generator, bound to the top level.
// Depends on apg_pkg.
`timescale 1ns / 1ps
module arc_point_generator_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input apg_pkg::apg_out_t m_data
);
    import apg_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An accepted request makes the block busy in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request input still open after a transfer");

    // A point that directly follows a non-last point carries the next index.
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            !m_valid || (m_data.point_index == 6'($past(m_data.point_index) + 6'd1)))
        else $error("point index out of sequence");

    // Reset leaves the output empty.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
endmodule

bind arc_point_generator arc_point_generator_checker u_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

>>> sim/arc_point_generator_test.sv
// Testbench for arc_point_generator: drives arc requests, predicts every point and
// checks the point transfers in order. Depends on apg_pkg and the design sources.
`timescale 1ns / 1ps
module arc_point_generator_test;
    import apg_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    apg_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    apg_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    arc_point_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the configuration registers.
    logic signed [15:0] cfg_radius = 16'sd2048;
    logic signed [15:0] cfg_xoff = 16'sd0;
    logic signed [15:0] cfg_yoff = 16'sd0;
    logic signed [15:0] cfg_xgain = 16'sd4096;
    logic signed [15:0] cfg_ygain = 16'sd4096;

    apg_in_t  pending_arcs[$];
    apg_out_t expected_points[$];
    int       error_count = 0;
    int       arcs_sent = 0;
    int       points_seen = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 8;
    int       recv_idle_pct = 85;
    int       recv_hold = 0;
    bit       hold_request = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint atan_step(int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            default: return 64'h0000517D;
        endcase
    endfunction

    // CORDIC rotation of a 16-bit binary angle, folded into the right half plane.
    task automatic rotate_angle(input logic [15:0] ang, output longint c, output longint s);
        longint a, x, y, z, dx, dy;
        bit neg;
        a = longint'($signed(ang));
        neg = 0;
        x = 652032874;
        y = 0;
        if (a >= 16384) begin
            a -= 32768; neg = 1;
        end else if (a < -16384) begin
            a += 32768; neg = 1;
        end
        z = a * 65536;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        x = round_shift(x, 30 - FRAC_BITS_DEF);
        y = round_shift(y, 30 - FRAC_BITS_DEF);
        if (neg) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic logic [15:0] scale_coord(longint trig, longint off, longint gain,
                                                inout bit clip);
        longint t, v;
        t = round_shift(trig * longint'(cfg_radius), FRAC_BITS_DEF) + off;
        v = round_shift(t * gain, 12);
        if (v > 32767) begin
            v = 32767; clip = 1;
        end
        if (v < -32768) begin
            v = -32768; clip = 1;
        end
        return v[15:0];
    endfunction

    // Expand one accepted arc request into its points.
    task automatic predict_arc(input apg_in_t req);
        longint b, e, c, s;
        int n, npts;
        logic [16:0] span;
        logic [15:0] ang;
        int unsigned step;
        apg_out_t p;
        bit clip;
        b = req.angle_begin;
        e = req.angle_end;
        if (b > e) begin
            c = b; b = e; e = c;
        end
        n = req.segment_count;
        if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
        span = 17'(e - b);
        npts = (n == 0) ? 1 : n + 1;
        for (int k = 0; k < npts; k++) begin
            step = (n == 0) ? 0 : (k * int'(span)) / n;
            ang = 16'(b + step);
            rotate_angle(ang, c, s);
            clip = 0;
            p.point_x = scale_coord(c, cfg_xoff, cfg_xgain, clip);
            p.point_y = scale_coord(s, cfg_yoff, cfg_ygain, clip);
            p.point_index = 6'(k);
            p.clipped = clip;
            p.last = (k + 1 == npts);
            expected_points = {expected_points, p};
        end
    endtask

    // Driver: offers queued requests, with random idle cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            predict_arc(s_data);
            arcs_sent++;
            if (pending_arcs.size() > 0 && !hold_request
                && $urandom_range(99) >= send_idle_pct) begin
                s_data <= pending_arcs.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid && pending_arcs.size() > 0 && !hold_request
                     && $urandom_range(99) >= send_idle_pct) begin
            s_valid <= 1'b1;
            s_data <= pending_arcs.pop_front();
        end
    end

    // Monitor: takes point transfers and compares them with the prediction.
    always @(posedge aclk) begin
        apg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point, actual %h", $time, m_data);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (m_data !== want) begin
                    $display("%0t: point mismatch, expected %h actual %h", $time, want, m_data);
                    error_count++;
                end
            end
        end
        if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("arc_point_generator_test: done, errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RADIUS:   cfg_radius = val;
            REG_X_OFFSET: cfg_xoff = val;
            REG_Y_OFFSET: cfg_yoff = val;
            REG_X_GAIN:   cfg_xgain = val;
            default:      cfg_ygain = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_arcs.size() > 0 || s_valid || expected_points.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] r, input logic [15:0] xo,
                              input logic [15:0] yo, input logic [15:0] xg,
                              input logic [15:0] yg);
        reg_write(REG_RADIUS, r);
        reg_write(REG_X_OFFSET, xo);
        reg_write(REG_Y_OFFSET, yo);
        reg_write(REG_X_GAIN, xg);
        reg_write(REG_Y_GAIN, yg);
    endtask

    function automatic apg_in_t make_arc(logic [15:0] b, logic [15:0] e, logic [5:0] n);
        apg_in_t a;
        a.angle_begin = b;
        a.angle_end = e;
        a.segment_count = n;
        return a;
    endfunction

    // Mostly short arcs; a few use the full segment count.
    function automatic apg_in_t random_arc();
        int r;
        logic [5:0] n;
        r = $urandom_range(99);
        if (r < 5) n = 6'd63;
        else if (r < 10) n = 6'd0;
        else n = 6'($urandom_range(1, 6));
        return make_arc(16'($urandom), 16'($urandom), n);
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed arcs at the default settings.
        pending_arcs = {pending_arcs, make_arc(16'h8000, 16'h7FFF, 6'd4)};
        pending_arcs = {pending_arcs, make_arc(16'h7FFF, 16'h8000, 6'd3)};
        pending_arcs = {pending_arcs, make_arc(16'h1234, 16'h5678, 6'd0)};
        pending_arcs = {pending_arcs, make_arc(16'h0100, 16'h0100, 6'd5)};
        pending_arcs = {pending_arcs, make_arc(16'h4000, 16'hC000, 6'd2)};
        pending_arcs = {pending_arcs, make_arc(16'h3FFF, 16'h4000, 6'd1)};
        pending_arcs = {pending_arcs, make_arc(16'hBFFF, 16'hC001, 6'd2)};
        pending_arcs = {pending_arcs, make_arc(16'h0000, 16'h7FFF, 6'd63)};
        pending_arcs = {pending_arcs, make_arc(16'h8000, 16'h0000, 6'd1)};
        pending_arcs = {pending_arcs, make_arc(16'h0000, 16'h0000, 6'd0)};
        wait_drained();

        // Extreme registers force saturation.
        set_config(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        pending_arcs = {pending_arcs, make_arc(16'h8000, 16'h7FFF, 6'd8)};
        pending_arcs = {pending_arcs, make_arc(16'h2000, 16'hE000, 6'd3)};
        wait_drained();
        set_config(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        pending_arcs = {pending_arcs, make_arc(16'hFFFF, 16'h0001, 6'd2)};
        pending_arcs = {pending_arcs, make_arc(16'h8000, 16'h7FFF, 6'd6)};
        wait_drained();

        // Long receiver stall while requests keep coming.
        set_config(16'd2048, 16'd0, 16'd0, 16'd4096, 16'd4096);
        recv_hold = 3000;
        for (int i = 0; i < 6; i++) pending_arcs = {pending_arcs, random_arc()};
        wait_drained();

        // Random phases: three idle patterns, each with fresh random registers.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 8 : 0;
            set_config(16'($urandom), 16'($urandom_range(0, 8191) - 4096),
                       16'($urandom_range(0, 8191) - 4096), 16'($urandom),
                       16'($urandom));
            for (int i = 0; i < 100; i++) begin
                pending_arcs = {pending_arcs, random_arc()};
                if (i == 50) begin
                    // Sender pause until all points are back.
                    while (pending_arcs.size() > 0 || s_valid) @(posedge aclk);
                    hold_request = 1'b1;
                    while (expected_points.size() > 0) @(posedge aclk);
                    hold_request = 1'b0;
                end
            end
            wait_drained();
        end

        $display("Covered %0d arc requests and %0d points over several register settings,",
                 arcs_sent, points_seen);
        $display("including saturation, zero counts, swapped angles and receiver stalls.");
        if (error_count == 0) begin
            $display("arc_point_generator_test: done, clean");
        end else begin
            $display("arc_point_generator_test: done, errors");
        end
        $finish;
    end
endmodule
